// ----- hdl/meur_pkg.sv -----
// Shared types and constants for the multiturn encoder unwrap block.
package meur_pkg;

    // Fixed field widths of the sample and result items.
    localparam int CH_IN_W     = 3;
    localparam int ANGLE_RAW_W = 13;
    localparam int RATE_W      = 14;
    localparam int TURN_W      = 16;
    localparam int POS_W       = 29;
    localparam int X_W         = 30;
    localparam int ANG_W       = 38;
    localparam int ALU_W       = 38;

    // Bias register file.
    localparam int CFG_IDX_W = 3;
    localparam int NUM_BIAS  = 7;

    // Encoder geometry: 8192 counts per turn, unwrap threshold at half a turn.
    localparam int HALF_TURN = 4096;
    localparam int FULL_TURN = 8192;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WIN_OUT,
        ST_WIN_IN,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_SIGN,
        ST_DONE
    } meur_state_t;

    // Request to the shared add/subtract unit.
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

// ----- hdl/meur_alu.sv -----
// Shared add/subtract unit used by every arithmetic step of the sequencer but the divide.
module meur_alu
    import meur_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W-1:0] y
);

    // One wide adder; subtraction by the same carry chain.
    always_comb begin
        if (req.sub) begin
            y = req.a - req.b;
        end else begin
            y = req.a + req.b;
        end
    end

endmodule

// ----- hdl/meur_win_mem.sv -----
// Rate window memory: one address, synchronous write and registered read.
module meur_win_mem #(
    parameter int DEPTH  = 56,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 14
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/multiturn_encoder_unwrap_rate.sv -----
// Top level: multiturn encoder unwrap with moving-average rate and angle scaling.
//
//  Channel  Ports                                   Handshake
//  -------  --------------------------------------  ------------------
//  sample   s_channel, s_angle_raw                  s_valid / s_ready
//  result   m_channel_out .. m_initial_angle        m_valid / m_ready
//  config   cfg_index, cfg_wdata                    cfg_wr_en
//
// Each sample runs through load, two window steps, three partial sums of the multiply
// by 360, magnitude, divide, sign, result hand-off and the return to idle before the
// next sample is accepted. The window sum is divided by one reciprocal multiply.
// Reset is synchronous and active low; it clears all per-channel state, and the
// window memory is masked by a per-channel fill flag instead of being cleared.
// A finished result waits in the output register while the next sample is taken;
// the sequencer stalls only when a second result is ready before the first is taken.
module multiturn_encoder_unwrap_rate
    import meur_pkg::*;
#(
    parameter int WINDOW_SIZE = 8,
    parameter int CHANNELS    = 7
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CH_IN_W-1:0]         s_channel,
    input  logic [ANGLE_RAW_W-1:0]     s_angle_raw,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CH_IN_W-1:0]         m_channel_out,
    output logic signed [POS_W-1:0]    m_continuous_position,
    output logic signed [TURN_W-1:0]   m_turn_count,
    output logic signed [RATE_W-1:0]   m_raw_rate,
    output logic signed [RATE_W-1:0]   m_filtered_rate,
    output logic signed [ANG_W-1:0]    m_angle_scaled,
    output logic signed [ANG_W-1:0]    m_initial_angle,

    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [ANGLE_RAW_W-1:0]     cfg_wdata
);

    localparam int CLOGW  = $clog2(WINDOW_SIZE);
    localparam int PTR_W  = (WINDOW_SIZE > 1) ? CLOGW : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH  = CHANNELS * WINDOW_SIZE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = RATE_W + CLOGW;
    localparam int MAG_W  = SUM_W - 1;
    localparam int CNT_W  = 2;
    // Reciprocal of the window size, exact for every magnitude below 2**MAG_W.
    localparam int DIV_K  = MAG_W + CLOGW;
    localparam int RCP_W  = MAG_W + 1;
    localparam int PROD_W = DIV_K + MAG_W;
    localparam int RECIP  = ((1 << DIV_K) + WINDOW_SIZE - 1) / WINDOW_SIZE;
    localparam logic [RCP_W-1:0] RECIP_V = RCP_W'(RECIP);

    // Sequencer.
    meur_state_t state_reg, state_next;
    logic [CNT_W-1:0] step_reg;

    // Configuration.
    logic [ANGLE_RAW_W-1:0] bias_reg [NUM_BIAS];

    // Per-channel state.
    logic [ANGLE_RAW_W-1:0]   last_angle_reg [CHANNELS];
    logic signed [TURN_W-1:0] turns_reg      [CHANNELS];
    logic [PTR_W-1:0]         ptr_reg        [CHANNELS];
    logic                     full_reg       [CHANNELS];
    logic                     seen_reg       [CHANNELS];
    logic signed [ANG_W-1:0]  first_reg      [CHANNELS];
    logic signed [SUM_W-1:0]  sum_reg        [CHANNELS];

    // Working registers of the current item.
    logic [CH_IN_W-1:0]        ch_reg;
    logic [ANGLE_RAW_W-1:0]    raw_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    logic signed [TURN_W-1:0]  turn_cur_reg;
    logic signed [POS_W-1:0]   pos_reg;
    logic signed [X_W-1:0]     x_reg;
    logic signed [ALU_W-1:0]   acc_reg;
    logic signed [ALU_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]   sum_cur_reg;
    logic                      neg_reg;
    logic [MAG_W-1:0]          quo_reg;
    logic signed [RATE_W-1:0]  frate_reg;

    // Output register.
    logic                      m_valid_reg;
    logic [CH_IN_W-1:0]        out_ch_reg;
    logic signed [POS_W-1:0]   out_pos_reg;
    logic signed [TURN_W-1:0]  out_turns_reg;
    logic signed [RATE_W-1:0]  out_rate_reg;
    logic signed [RATE_W-1:0]  out_frate_reg;
    logic signed [ANG_W-1:0]   out_ang_reg;
    logic signed [ANG_W-1:0]   out_init_reg;

    logic                      in_accept;
    logic                      ch_ok;
    logic                      out_load;
    logic                      mem_we;
    logic [CH_W-1:0]           ch_idx;
    logic [ADDR_W-1:0]         win_addr;
    logic [RATE_W-1:0]         win_rdata;
    logic signed [RATE_W-1:0]  win_old;
    alu_req_t                  alu_req;
    logic [ALU_W-1:0]          alu_y;
    logic signed [ALU_W-1:0]   alu_sy;
    logic [ANGLE_RAW_W-1:0]    cur_bias;
    logic signed [14:0]        diff;
    logic signed [14:0]        rate_wide;
    logic signed [TURN_W-1:0]  turn_new;
    logic signed [POS_W-1:0]   pos_new;
    logic signed [ALU_W-1:0]   x_ext;
    logic [PROD_W-1:0]         div_prod;

    assign in_accept = s_valid && s_ready;
    assign ch_ok     = 5'(s_channel) < 5'(CHANNELS);
    assign ch_idx    = CH_W'(ch_reg);
    assign win_addr  = ADDR_W'(int'(ch_idx) * WINDOW_SIZE + int'(ptr_reg[ch_idx]));
    assign alu_sy    = $signed(alu_y);
    assign x_ext     = ALU_W'(x_reg);
    assign cur_bias  = (ch_reg < CH_IN_W'(NUM_BIAS)) ? bias_reg[ch_reg] : '0;
    // An entry not yet written since reset counts as zero.
    assign win_old   = full_reg[ch_idx] ? $signed(win_rdata) : '0;
    // Magnitude times the reciprocal; the upper bits are the truncated quotient.
    assign div_prod  = PROD_W'(quo_reg) * PROD_W'(RECIP_V);

    // Unwrap the angle difference against the previous sample of this channel.
    always_comb begin
        diff     = $signed({2'b00, raw_reg}) - $signed({2'b00, last_angle_reg[ch_idx]});
        turn_new = turns_reg[ch_idx];
        if (diff < -HALF_TURN) begin
            rate_wide = diff + 15'(FULL_TURN);
            if (turn_new != TURN_MAX) begin
                turn_new = turn_new + 16'sd1;
            end
        end else if (diff > HALF_TURN) begin
            rate_wide = diff - 15'(FULL_TURN);
            if (turn_new != TURN_MIN) begin
                turn_new = turn_new - 16'sd1;
            end
        end else begin
            rate_wide = diff;
        end
        pos_new = {turn_new, raw_reg};
    end

    meur_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    meur_win_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (RATE_W)
    ) u_win_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (win_addr),
        .wdata (rate_reg),
        .rdata (win_rdata)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && ch_ok) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:    state_next = ST_WIN_OUT;
            ST_WIN_OUT: state_next = ST_WIN_IN;
            ST_WIN_IN:  state_next = ST_MUL;
            ST_MUL: begin
                if (step_reg == CNT_W'(2)) begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_SIGN;
            ST_SIGN: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshakes, memory write and the shared adder's operands.
    always_comb begin
        s_ready     = 1'b0;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOAD: begin
                // Offset position: turns*8192 + raw - bias.
                alu_req.a   = ALU_W'(pos_new);
                alu_req.b   = ALU_W'(cur_bias);
                alu_req.sub = 1'b1;
            end
            ST_WIN_OUT: begin
                alu_req.a   = ALU_W'(sum_reg[ch_idx]);
                alu_req.b   = ALU_W'(win_old);
                alu_req.sub = 1'b1;
            end
            ST_WIN_IN: begin
                alu_req.a = acc_reg;
                alu_req.b = ALU_W'(rate_reg);
                mem_we    = 1'b1;
            end
            ST_MUL: begin
                // 360 = 256 + 64 + 32 + 8, one partial sum per step.
                case (step_reg)
                    CNT_W'(0): begin
                        alu_req.a = x_ext <<< 8;
                        alu_req.b = x_ext <<< 6;
                    end
                    CNT_W'(1): begin
                        alu_req.a = prod_reg;
                        alu_req.b = x_ext <<< 5;
                    end
                    default: begin
                        alu_req.a = prod_reg;
                        alu_req.b = x_ext <<< 3;
                    end
                endcase
            end
            ST_ABS: begin
                alu_req.b   = ALU_W'(sum_cur_reg);
                alu_req.sub = 1'b1;
            end
            ST_SIGN: begin
                alu_req.b   = ALU_W'(quo_reg);
                alu_req.sub = neg_reg;
            end
            ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control state, configuration and per-channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BIAS; i++) begin
                bias_reg[i] <= '0;
            end
            for (int c = 0; c < CHANNELS; c++) begin
                last_angle_reg[c] <= '0;
                turns_reg[c]      <= '0;
                ptr_reg[c]        <= '0;
                full_reg[c]       <= 1'b0;
                seen_reg[c]       <= 1'b0;
                first_reg[c]      <= '0;
                sum_reg[c]        <= '0;
            end
        end else begin
            state_reg <= state_next;

            // Step counter for the multiply loop.
            if (state_next != state_reg) begin
                step_reg <= '0;
            end else if (state_reg == ST_MUL) begin
                step_reg <= step_reg + CNT_W'(1);
            end

            if (cfg_wr_en && cfg_index < CFG_IDX_W'(NUM_BIAS)) begin
                bias_reg[cfg_index] <= cfg_wdata;
            end

            if (state_reg == ST_LOAD) begin
                last_angle_reg[ch_idx] <= raw_reg;
                turns_reg[ch_idx]      <= turn_new;
            end

            // Window write: advance the pointer and mark the window full on wrap.
            if (state_reg == ST_WIN_IN) begin
                sum_reg[ch_idx] <= SUM_W'(alu_sy);
                if (ptr_reg[ch_idx] == PTR_W'(WINDOW_SIZE - 1)) begin
                    ptr_reg[ch_idx]  <= '0;
                    full_reg[ch_idx] <= 1'b1;
                end else begin
                    ptr_reg[ch_idx] <= ptr_reg[ch_idx] + PTR_W'(1);
                end
            end

            if (out_load) begin
                seen_reg[ch_idx] <= 1'b1;
                if (!seen_reg[ch_idx]) begin
                    first_reg[ch_idx] <= prod_reg;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers of the current item.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_accept) begin
            ch_reg  <= s_channel;
            raw_reg <= s_angle_raw;
        end
        case (state_reg)
            ST_LOAD: begin
                rate_reg     <= RATE_W'(rate_wide);
                turn_cur_reg <= turn_new;
                pos_reg      <= pos_new;
                x_reg        <= X_W'(alu_sy);
            end
            ST_WIN_OUT: begin
                acc_reg <= alu_sy;
            end
            ST_WIN_IN: begin
                sum_cur_reg <= SUM_W'(alu_sy);
            end
            ST_MUL: begin
                prod_reg <= alu_sy;
            end
            ST_ABS: begin
                neg_reg <= sum_cur_reg[SUM_W-1];
                if (sum_cur_reg[SUM_W-1]) begin
                    quo_reg <= alu_y[MAG_W-1:0];
                end else begin
                    quo_reg <= sum_cur_reg[MAG_W-1:0];
                end
            end
            ST_DIV: begin
                // Divide the magnitude by the window size, truncating.
                quo_reg <= div_prod[PROD_W-1:DIV_K];
            end
            ST_SIGN: begin
                frate_reg <= RATE_W'(alu_sy);
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_ch_reg    <= ch_reg;
            out_pos_reg   <= pos_reg;
            out_turns_reg <= turn_cur_reg;
            out_rate_reg  <= rate_reg;
            out_frate_reg <= frate_reg;
            out_ang_reg   <= prod_reg;
            out_init_reg  <= seen_reg[ch_idx] ? first_reg[ch_idx] : prod_reg;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_channel_out         = out_ch_reg;
    assign m_continuous_position = out_pos_reg;
    assign m_turn_count          = out_turns_reg;
    assign m_raw_rate            = out_rate_reg;
    assign m_filtered_rate       = out_frate_reg;
    assign m_angle_scaled        = out_ang_reg;
    assign m_initial_angle       = out_init_reg;

    // The averaged rate never leaves the range of a single raw rate.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (frate_reg >= -HALF_TURN && frate_reg <= HALF_TURN))
        else $error("filtered rate out of range");

    // The window pointer of the active channel stays inside the window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WIN_IN |-> int'(ptr_reg[ch_idx]) < WINDOW_SIZE)
        else $error("window pointer out of range");

    // The divide step always hands over to the sign step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |=> state_reg == ST_SIGN)
        else $error("divide step not followed by sign step");

    // A sample for a known channel always starts the sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && ch_ok) |=> state_reg == ST_LOAD)
        else $error("accepted item not processed");

endmodule

// ----- bench/tb_multiturn_encoder_unwrap_rate.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the multiturn encoder unwrap block, with its own prediction.
module tb_multiturn_encoder_unwrap_rate
    import meur_pkg::*;
();

    localparam int WIN_SIZE    = 8;
    localparam int CHAN_COUNT  = 7;
    localparam int SINK_HOLD   = 250;   // long receiver stall that backs up the block
    localparam int SETTLE      = 40;    // covers one sample in flight
    localparam int QUIET_LIMIT = 4000;  // cycles without any handshake before giving up
    localparam int PHASE_ITEMS = 270;
    localparam int SWEEP_STEPS = 24;

    // Bias settings used between phases.
    typedef enum {BIAS_ZERO, BIAS_FULL, BIAS_MIXED, BIAS_RANDOM} bias_plan_t;

    // How the next angle of a channel is derived from its previous one.
    typedef enum {WALK_FIXED, WALK_SMALL, WALK_WIDE, WALK_EDGE, WALK_JUMP} walk_t;

    typedef struct packed {
        logic [CH_IN_W-1:0]        channel;
        logic signed [POS_W-1:0]   position;
        logic signed [TURN_W-1:0]  turns;
        logic signed [RATE_W-1:0]  raw_rate;
        logic signed [RATE_W-1:0]  filt_rate;
        logic signed [ANG_W-1:0]   angle;
        logic signed [ANG_W-1:0]   first_angle;
    } enc_result_t;

    // Tracks per-channel unwrap state and holds the results still owed by the block.
    class unwrap_scoreboard;
        logic [ANGLE_RAW_W-1:0] bias_copy [NUM_BIAS];
        logic [ANGLE_RAW_W-1:0] prev_angle [CHAN_COUNT];
        int          turns [CHAN_COUNT];
        int          rate_hist [CHAN_COUNT][WIN_SIZE];
        int          hist_ptr [CHAN_COUNT];
        bit          seen [CHAN_COUNT];
        longint      origin_angle [CHAN_COUNT];
        enc_result_t expected_results [$];
        int          errors;
        int          checked;
        int          top_turns;

        function new();
            foreach (bias_copy[i]) bias_copy[i] = '0;
            foreach (prev_angle[c]) begin
                prev_angle[c] = '0;
                turns[c] = 0;
                hist_ptr[c] = 0;
                seen[c] = 1'b0;
                origin_angle[c] = 0;
                for (int k = 0; k < WIN_SIZE; k++) rate_hist[c][k] = 0;
            end
            errors = 0;
            checked = 0;
            top_turns = 0;
        endfunction

        function void set_bias(int idx, int val);
            if (idx < NUM_BIAS) bias_copy[idx] = val[ANGLE_RAW_W-1:0];
        endfunction

        // Unwrap one accepted sample and queue the result it must produce.
        function void note_sample(int ch, int raw);
            int          diff;
            int          rate;
            int          sum;
            int          bias;
            longint      ang;
            enc_result_t r;
            if (ch >= CHAN_COUNT) return;

            diff = raw - int'(prev_angle[ch]);
            prev_angle[ch] = raw[ANGLE_RAW_W-1:0];
            if (diff < -HALF_TURN) begin
                if (turns[ch] < int'(TURN_MAX)) turns[ch]++;
                rate = diff + FULL_TURN;
            end else if (diff > HALF_TURN) begin
                if (turns[ch] > int'(TURN_MIN)) turns[ch]--;
                rate = diff - FULL_TURN;
            end else begin
                rate = diff;
            end
            if (turns[ch] > top_turns) top_turns = turns[ch];

            bias = (ch < NUM_BIAS) ? int'(bias_copy[ch]) : 0;
            ang = 360 * (longint'(raw - bias) + longint'(turns[ch]) * FULL_TURN);

            // Moving window of raw rates, averaged with truncation toward zero.
            rate_hist[ch][hist_ptr[ch]] = rate;
            hist_ptr[ch] = (hist_ptr[ch] + 1) % WIN_SIZE;
            sum = 0;
            for (int k = 0; k < WIN_SIZE; k++) sum += rate_hist[ch][k];

            if (!seen[ch]) origin_angle[ch] = ang;
            seen[ch] = 1'b1;

            r.channel     = ch[CH_IN_W-1:0];
            r.position    = raw + turns[ch] * FULL_TURN;
            r.turns       = turns[ch];
            r.raw_rate    = rate;
            r.filt_rate   = sum / WIN_SIZE;
            r.angle       = ang;
            r.first_angle = origin_angle[ch];
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH %s", msg);
        endtask

        task compare_field(string fname, longint got, longint want);
            if (got != want)
                report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                          checked, fname, got, want));
        endtask

        task check_result(enc_result_t got);
            enc_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result on channel %0d with no sample waiting",
                                          got.channel));
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("channel_out", got.channel, want.channel);
            compare_field("continuous_position", got.position, want.position);
            compare_field("turn_count", got.turns, want.turns);
            compare_field("raw_rate", got.raw_rate, want.raw_rate);
            compare_field("filtered_rate", got.filt_rate, want.filt_rate);
            compare_field("angle_scaled", got.angle, want.angle);
            compare_field("initial_angle", got.first_angle, want.first_angle);
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [CH_IN_W-1:0]         s_channel;
    logic [ANGLE_RAW_W-1:0]     s_angle_raw;
    logic                       m_valid;
    logic                       m_ready;
    logic [CH_IN_W-1:0]         m_channel_out;
    logic signed [POS_W-1:0]    m_continuous_position;
    logic signed [TURN_W-1:0]   m_turn_count;
    logic signed [RATE_W-1:0]   m_raw_rate;
    logic signed [RATE_W-1:0]   m_filtered_rate;
    logic signed [ANG_W-1:0]    m_angle_scaled;
    logic signed [ANG_W-1:0]    m_initial_angle;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [ANGLE_RAW_W-1:0]     cfg_wdata;

    unwrap_scoreboard board;
    bit  steady;        // suppresses random idling on both sides
    bit  hold_pending;  // asks the result side for one long stall
    int  hold_left;
    int  quiet_cycles;
    int  samples_sent;
    int  ignored_sent;
    int  bias_writes;

    multiturn_encoder_unwrap_rate #(
        .WINDOW_SIZE(WIN_SIZE),
        .CHANNELS   (CHAN_COUNT)
    ) dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_channel            (s_channel),
        .s_angle_raw          (s_angle_raw),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_channel_out        (m_channel_out),
        .m_continuous_position(m_continuous_position),
        .m_turn_count         (m_turn_count),
        .m_raw_rate           (m_raw_rate),
        .m_filtered_rate      (m_filtered_rate),
        .m_angle_scaled       (m_angle_scaled),
        .m_initial_angle      (m_initial_angle),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: check each accepted item, then pick the ready level for the next cycle.
    always @(posedge aclk) begin : result_sink
        enc_result_t got;
        if (m_valid && m_ready) begin
            got.channel     = m_channel_out;
            got.position    = m_continuous_position;
            got.turns       = m_turn_count;
            got.raw_rate    = m_raw_rate;
            got.filt_rate   = m_filtered_rate;
            got.angle       = m_angle_scaled;
            got.first_angle = m_initial_angle;
            board.check_result(got);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_pending) begin
            hold_pending <= 1'b0;
            hold_left <= SINK_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 37);
        end
    end

    // Watchdog: a long run of cycles without any handshake means the block hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("multiturn_encoder_unwrap_rate verification failed");
            $finish;
        end
    end

    // Offer one sample, hold it until accepted, then record it for prediction.
    task automatic send_sample(int ch, int ang);
        while (!steady && $urandom_range(0, 99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_channel <= ch[CH_IN_W-1:0];
        s_angle_raw <= ang[ANGLE_RAW_W-1:0];
        do @(posedge aclk); while (!s_ready);
        board.note_sample(ch, ang);
        samples_sent++;
        if (ch >= CHAN_COUNT) ignored_sent++;
    endtask

    // Stop offering, wait for every owed result, then wait out the SETTLE period.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write every bias register, plus the unmapped index, which must be ignored.
    task automatic load_biases(bias_plan_t plan);
        int val;
        for (int idx = 0; idx <= NUM_BIAS; idx++) begin
            case (plan)
                BIAS_ZERO: val = 0;
                BIAS_FULL: val = FULL_TURN - 1;
                BIAS_MIXED: val = (idx % 3 == 0) ? 0 : (idx % 3 == 1) ? FULL_TURN - 1 : 1;
                default: val = $urandom_range(0, FULL_TURN - 1);
            endcase
            if (idx == NUM_BIAS) val = $urandom_range(0, FULL_TURN - 1);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[CFG_IDX_W-1:0];
            cfg_wdata <= val[ANGLE_RAW_W-1:0];
            @(posedge aclk);
            board.set_bias(idx, val);
            bias_writes++;
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Next angle for a channel, stepping from its last angle (random for the unmapped channel), or a jump.
    function automatic int next_angle(int ch, walk_t walk, int fixed_step);
        int base;
        int step;
        int pick;
        int mag;
        base = (ch < CHAN_COUNT) ? int'(board.prev_angle[ch]) : $urandom_range(0, FULL_TURN - 1);
        case (walk)
            WALK_FIXED: step = fixed_step;
            WALK_SMALL: step = int'($urandom_range(0, 128)) - 64;
            WALK_WIDE: step = int'($urandom_range(0, FULL_TURN)) - HALF_TURN;
            WALK_EDGE: begin
                // Steps right around the half-turn threshold, and full near-turns.
                pick = $urandom_range(0, 7);
                mag = (pick < 6) ? HALF_TURN - 1 + pick / 2 : FULL_TURN - 1;
                step = pick[0] ? -mag : mag;
            end
            default: begin
                pick = $urandom_range(0, 3);
                return (pick == 0) ? 0 : (pick == 1) ? FULL_TURN - 1
                                                     : $urandom_range(0, FULL_TURN - 1);
            end
        endcase
        return (base + step) & (FULL_TURN - 1);
    endfunction

    // Bursts of samples on one channel, so windows fill with related rates.
    task automatic random_phase(int count);
        int    done;
        int    ch;
        int    len;
        int    fixed_step;
        walk_t walk;
        done = 0;
        while (done < count) begin
            ch = ($urandom_range(0, 19) == 0) ? CHAN_COUNT : $urandom_range(0, CHAN_COUNT - 1);
            len = $urandom_range(1, 12);
            walk = walk_t'($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0) begin
                fixed_step = $urandom_range(0, 1) ? HALF_TURN - 1 : 1 - HALF_TURN;
            end else begin
                fixed_step = int'($urandom_range(0, FULL_TURN - 2)) - (HALF_TURN - 1);
            end
            repeat (len) begin
                send_sample(ch, next_angle(ch, walk, fixed_step));
                if (ch < CHAN_COUNT) done++;
            end
        end
    endtask

    // Drive one channel forward by nearly half a turn per sample, so the turn count
    // climbs by one every other sample, then bring it back down the same way.
    task automatic turn_sweep_run(int ch);
        steady <= 1'b1;
        repeat (SWEEP_STEPS)
            send_sample(ch, (board.prev_angle[ch] + HALF_TURN - 1) & (FULL_TURN - 1));
        repeat (SWEEP_STEPS)
            send_sample(ch, (board.prev_angle[ch] - HALF_TURN + 1) & (FULL_TURN - 1));
        steady <= 1'b0;
    endtask

    // Directed samples: first samples, exact and just-over half turns, wraps both ways,
    // the unmapped channel, and extreme angles.
    task automatic directed_samples();
        int chs [22] = '{0, 1, 2, 3, 2, 2, 2, 2, 7, 7, 4, 5, 6, 6, 6,
                         0, 0, 0, 0, 1, 1, 1};
        int angs [22] = '{0, 8191, 4096, 4097, 0, 4096, 8191, 0, 8191, 0, 1, 8190,
                          4095, 8191, 0, 4095, 8190, 4093, 8188, 4096, 1, 4098};
        foreach (chs[i]) send_sample(chs[i], angs[i]);
    endtask

    // Stimulus: reset, then phases with different bias settings and idling patterns.
    initial begin
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_channel = '0;
        s_angle_raw = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_samples();
        drain_results();

        load_biases(BIAS_FULL);
        random_phase(PHASE_ITEMS);
        drain_results();

        // Receiver stalls for a long stretch while samples keep coming.
        load_biases(BIAS_RANDOM);
        hold_pending <= 1'b1;
        steady <= 1'b1;
        repeat (8) send_sample($urandom_range(0, CHAN_COUNT - 1), $urandom_range(0, 8191));
        steady <= 1'b0;
        random_phase(PHASE_ITEMS);
        drain_results();

        // A long stretch with both sides always ready.
        load_biases(BIAS_MIXED);
        steady <= 1'b1;
        random_phase(PHASE_ITEMS);
        steady <= 1'b0;
        drain_results();

        load_biases(BIAS_ZERO);
        random_phase(PHASE_ITEMS);
        drain_results();

        load_biases(BIAS_RANDOM);
        turn_sweep_run(5);
        drain_results();

        $display("Run covered %0d samples (%0d on the unmapped channel) over %0d bias writes.",
                 samples_sent, ignored_sent, bias_writes);
        $display("Checked %0d results; the highest turn count seen was %0d.",
                 board.checked, board.top_turns);
        if (board.errors == 0 && board.expected_results.size() == 0) begin
            $display("multiturn_encoder_unwrap_rate verification clean");
        end else begin
            $display("multiturn_encoder_unwrap_rate verification failed");
        end
        $finish;
    end

endmodule
